### rtl/mwsf_pkg.sv
package mwsf_pkg;

	// field and register widths
	localparam int VEL_W   = 16;
	localparam int GAIN_W  = 24;
	localparam int AXLE_W  = 12;
	localparam int LIMIT_W = 15;
	localparam int SPEED_W = 16;
	localparam int BYTE_W  = 8;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = GAIN_W;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_GAIN  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_AXLE_SUM    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT = 2'd2;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd924860;
	localparam logic [AXLE_W-1:0]  AXLE_RESET  = 12'd595;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd4400;

	localparam int WHEELS  = 4;
	localparam int WHEEL_W = $clog2(WHEELS);

	// arithmetic widths
	localparam int ROT_W       = 28;                   // yaw rate times axle sum
	localparam int BASE_W      = 27;                   // 1000 * (vx +/- vy)
	localparam int SUM_W       = 29;                   // wheel sums
	localparam int SMAG_W      = SUM_W - 1;
	localparam int GAIN_HALF_W = GAIN_W / 2;
	localparam int PROD_W      = SMAG_W + GAIN_HALF_W;
	localparam int ACC_W       = SMAG_W + GAIN_W;
	localparam int Q16_SHIFT   = 16;
	localparam int MAG_W       = 26;                   // speed magnitude before limiting
	localparam int DIV_W       = MAG_W + LIMIT_W;
	localparam int MILLI       = 1000;
	localparam logic signed [10:0] MILLI_S = 11'sd1000;
	localparam int LIMIT_STEPS = LIMIT_W;              // quotient bits of the limit divide
	localparam int STEP_W      = $clog2(LIMIT_STEPS);

	// divide by 1000 through the reciprocal floor(2^36 / 1000)
	localparam int NUM_W       = ACC_W - Q16_SHIFT;    // product with the q16 fraction dropped
	localparam int NUM_HALF_W  = NUM_W / 2;
	localparam int RCP_W       = 27;
	localparam logic [RCP_W-1:0] RCP_MILLI = 27'd68719476;
	localparam int RPROD_W     = NUM_HALF_W + RCP_W;
	localparam int RESID_W     = 11;                   // remainder of the estimate stays below 2000

	localparam int QUEUE_DEPTH = 2;

	// frame bytes
	localparam logic [BYTE_W-1:0] FRAME_START = 8'h02;
	localparam logic [BYTE_W-1:0] FRAME_END   = 8'h03;
	localparam logic [BYTE_W-1:0] TAG_FIRST   = 8'h41;

	typedef logic [WHEELS-1:0][SPEED_W-1:0] speed_set_t;

	typedef struct packed {
		logic                     start_gain;
		logic                     start_limit;
		logic signed [SUM_W-1:0]  sum;
		logic [GAIN_W-1:0]        gain;
		logic [LIMIT_W-1:0]       limit;
		logic [MAG_W-1:0]         peak;
	} lane_cmd_t;

	typedef struct packed {
		logic              busy;
		logic              neg;
		logic [MAG_W-1:0]  mag;
	} lane_status_t;

endpackage

### rtl/mwsf_lane.sv
module mwsf_lane (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mwsf_pkg::lane_cmd_t     cmd,
	output mwsf_pkg::lane_status_t  status
);

	typedef enum logic [3:0] {
		L_IDLE, L_MUL_LO, L_MUL_HI, L_ACC, L_RCP_LO, L_RCP_HI, L_EST, L_FIX, L_DIV
	} lane_state_t;

	lane_state_t                        state_q;
	logic                               neg_q;
	logic [mwsf_pkg::SMAG_W-1:0]        smag_q;
	logic [mwsf_pkg::PROD_W-1:0]        prod_q;
	logic [mwsf_pkg::ACC_W-1:0]         acc_q;
	logic [mwsf_pkg::NUM_W-1:0]         num_q;
	logic [mwsf_pkg::RPROD_W-1:0]       rprod_q;
	logic [mwsf_pkg::RCP_W-1:0]         rcarry_q;
	logic [mwsf_pkg::MAG_W-1:0]         est_q;
	logic [mwsf_pkg::DIV_W-1:0]         rem_q;
	logic [mwsf_pkg::DIV_W-1:0]         dsh_q;
	logic [mwsf_pkg::MAG_W-1:0]         quo_q;
	logic [mwsf_pkg::MAG_W-1:0]         mag_q;
	logic [mwsf_pkg::STEP_W-1:0]        step_q;

	logic signed [mwsf_pkg::SUM_W-1:0]  sum_abs;
	logic [mwsf_pkg::PROD_W-1:0]        lo_prod;
	logic [mwsf_pkg::PROD_W-1:0]        hi_prod;
	logic [mwsf_pkg::ACC_W-1:0]         acc_sum;
	logic [mwsf_pkg::RPROD_W-1:0]       rcp_lo;
	logic [mwsf_pkg::RPROD_W-1:0]       rcp_hi;
	logic [mwsf_pkg::RPROD_W:0]         rcp_sum;
	logic [mwsf_pkg::RESID_W-1:0]       est_milli;
	logic [mwsf_pkg::RESID_W-1:0]       resid;
	logic                               round_up;
	logic [mwsf_pkg::DIV_W-1:0]         lim_prod;
	logic                               quo_bit;
	logic [mwsf_pkg::DIV_W-1:0]         rem_next;
	logic [mwsf_pkg::MAG_W-1:0]         quo_next;

	assign sum_abs  = cmd.sum[mwsf_pkg::SUM_W-1] ? -cmd.sum : cmd.sum;
	assign lo_prod  = smag_q * cmd.gain[mwsf_pkg::GAIN_HALF_W-1:0];
	assign hi_prod  = smag_q * cmd.gain[mwsf_pkg::GAIN_W-1:mwsf_pkg::GAIN_HALF_W];
	assign acc_sum  = acc_q + {prod_q, {mwsf_pkg::GAIN_HALF_W{1'b0}}};
	assign lim_prod = mag_q * cmd.limit;

	// reciprocal estimate of the divide by 1000 is exact or one short
	assign rcp_lo    = num_q[mwsf_pkg::NUM_HALF_W-1:0] * mwsf_pkg::RCP_MILLI;
	assign rcp_hi    = num_q[mwsf_pkg::NUM_W-1:mwsf_pkg::NUM_HALF_W] * mwsf_pkg::RCP_MILLI;
	assign rcp_sum   = {1'b0, rprod_q} + (mwsf_pkg::RPROD_W + 1)'(rcarry_q);
	// only the low bits of the remainder matter, it is below 2000
	assign est_milli = est_q[mwsf_pkg::RESID_W-1:0] * mwsf_pkg::RESID_W'(mwsf_pkg::MILLI);
	assign resid     = num_q[mwsf_pkg::RESID_W-1:0] - est_milli;
	assign round_up  = (resid >= mwsf_pkg::RESID_W'(mwsf_pkg::MILLI));

	// one restoring step: the divisor is pre-shifted and walks right
	assign quo_bit  = (rem_q >= dsh_q);
	assign rem_next = quo_bit ? (rem_q - dsh_q) : rem_q;
	assign quo_next = {quo_q[mwsf_pkg::MAG_W-2:0], quo_bit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= L_IDLE;
			neg_q    <= 1'b0;
			smag_q   <= '0;
			prod_q   <= '0;
			acc_q    <= '0;
			num_q    <= '0;
			rprod_q  <= '0;
			rcarry_q <= '0;
			est_q    <= '0;
			rem_q    <= '0;
			dsh_q    <= '0;
			quo_q    <= '0;
			mag_q    <= '0;
			step_q   <= '0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (cmd.start_gain) begin
						neg_q   <= cmd.sum[mwsf_pkg::SUM_W-1];
						smag_q  <= sum_abs[mwsf_pkg::SMAG_W-1:0];
						state_q <= L_MUL_LO;
					end else if (cmd.start_limit) begin
						// magnitude times limit over the largest magnitude
						rem_q   <= lim_prod;
						dsh_q   <= mwsf_pkg::DIV_W'(cmd.peak) << (mwsf_pkg::LIMIT_STEPS - 1);
						quo_q   <= '0;
						step_q  <= mwsf_pkg::STEP_W'(mwsf_pkg::LIMIT_STEPS - 1);
						state_q <= L_DIV;
					end
				end
				L_MUL_LO: begin
					prod_q  <= lo_prod;
					state_q <= L_MUL_HI;
				end
				L_MUL_HI: begin
					acc_q   <= mwsf_pkg::ACC_W'(prod_q);
					prod_q  <= hi_prod;
					state_q <= L_ACC;
				end
				L_ACC: begin
					// drop the q16 fraction, then divide by 1000
					num_q   <= acc_sum[mwsf_pkg::ACC_W-1:mwsf_pkg::Q16_SHIFT];
					state_q <= L_RCP_LO;
				end
				L_RCP_LO: begin
					rprod_q <= rcp_lo;
					state_q <= L_RCP_HI;
				end
				L_RCP_HI: begin
					rcarry_q <= rprod_q[mwsf_pkg::RPROD_W-1:mwsf_pkg::NUM_HALF_W];
					rprod_q  <= rcp_hi;
					state_q  <= L_EST;
				end
				L_EST: begin
					est_q   <= rcp_sum[mwsf_pkg::NUM_HALF_W+mwsf_pkg::MAG_W-1:mwsf_pkg::NUM_HALF_W];
					state_q <= L_FIX;
				end
				L_FIX: begin
					mag_q   <= est_q + mwsf_pkg::MAG_W'(round_up);
					state_q <= L_IDLE;
				end
				L_DIV: begin
					rem_q <= rem_next;
					dsh_q <= dsh_q >> 1;
					quo_q <= quo_next;
					if (step_q == '0) begin
						mag_q   <= quo_next;
						state_q <= L_IDLE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign status.busy = (state_q != L_IDLE);
	assign status.neg  = neg_q;
	assign status.mag  = mag_q;

endmodule

### rtl/mwsf_front.sv
module mwsf_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_stall,
	input  logic signed [mwsf_pkg::VEL_W-1:0]  vel_forward_mm_s,
	input  logic signed [mwsf_pkg::VEL_W-1:0]  vel_lateral_mm_s,
	input  logic signed [mwsf_pkg::VEL_W-1:0]  yaw_rate_mrad_s,
	input  logic [mwsf_pkg::GAIN_W-1:0]        speed_gain_q16,
	input  logic [mwsf_pkg::AXLE_W-1:0]        axle_sum_mm,
	input  logic [mwsf_pkg::LIMIT_W-1:0]       speed_limit,
	output logic                               push,
	output mwsf_pkg::speed_set_t               push_data,
	input  logic                               queue_full
);

	typedef enum logic [2:0] {
		F_IDLE, F_SUM, F_GAIN, F_GAIN_WAIT, F_MAX, F_CHECK, F_LIMIT_WAIT, F_PUSH
	} front_state_t;

	front_state_t                          state_q;
	logic                                  hold_valid_q;
	logic signed [mwsf_pkg::VEL_W-1:0]     vx_q;
	logic signed [mwsf_pkg::VEL_W-1:0]     vy_q;
	logic signed [mwsf_pkg::VEL_W-1:0]     wz_q;
	logic signed [mwsf_pkg::ROT_W-1:0]     rot_q;
	logic signed [mwsf_pkg::BASE_W-1:0]    diff_base_q;
	logic signed [mwsf_pkg::BASE_W-1:0]    add_base_q;
	logic signed [mwsf_pkg::SUM_W-1:0]     s_q [mwsf_pkg::WHEELS];
	logic [mwsf_pkg::MAG_W-1:0]            peak_q;

	logic                                  accept;
	logic                                  take;
	logic signed [mwsf_pkg::ROT_W-1:0]     rot;
	logic signed [mwsf_pkg::VEL_W:0]       vdiff;
	logic signed [mwsf_pkg::VEL_W:0]       vadd;
	logic signed [mwsf_pkg::BASE_W-1:0]    diff_base;
	logic signed [mwsf_pkg::BASE_W-1:0]    add_base;
	logic [mwsf_pkg::MAG_W-1:0]            max_a;
	logic [mwsf_pkg::MAG_W-1:0]            max_b;
	logic [mwsf_pkg::MAG_W-1:0]            max_all;
	logic                                  over_limit;
	logic                                  any_busy;
	mwsf_pkg::lane_cmd_t                   lane_cmd [mwsf_pkg::WHEELS];
	mwsf_pkg::lane_status_t                lane_st  [mwsf_pkg::WHEELS];

	// one holding register in front of the sequencer
	assign cmd_stall = hold_valid_q;
	assign accept    = cmd_valid && !hold_valid_q;
	assign take      = (state_q == F_IDLE) && hold_valid_q;

	assign rot       = wz_q * $signed({1'b0, axle_sum_mm});
	assign vdiff     = vx_q - vy_q;
	assign vadd      = vx_q + vy_q;
	assign diff_base = vdiff * mwsf_pkg::MILLI_S;
	assign add_base  = vadd * mwsf_pkg::MILLI_S;

	assign max_a   = (lane_st[0].mag > lane_st[1].mag) ? lane_st[0].mag : lane_st[1].mag;
	assign max_b   = (lane_st[2].mag > lane_st[3].mag) ? lane_st[2].mag : lane_st[3].mag;
	assign max_all = (max_a > max_b) ? max_a : max_b;

	assign over_limit = (peak_q > mwsf_pkg::MAG_W'(speed_limit));
	assign any_busy   = lane_st[0].busy || lane_st[1].busy || lane_st[2].busy || lane_st[3].busy;
	assign push       = (state_q == F_PUSH) && !queue_full;

	for (genvar i = 0; i < mwsf_pkg::WHEELS; i++) begin : g_lane
		assign lane_cmd[i].start_gain  = (state_q == F_GAIN);
		assign lane_cmd[i].start_limit = (state_q == F_CHECK) && over_limit;
		assign lane_cmd[i].sum         = s_q[i];
		assign lane_cmd[i].gain        = speed_gain_q16;
		assign lane_cmd[i].limit       = speed_limit;
		assign lane_cmd[i].peak        = peak_q;
		assign push_data[i] = lane_st[i].neg
			? (mwsf_pkg::SPEED_W'(0) - lane_st[i].mag[mwsf_pkg::SPEED_W-1:0])
			: lane_st[i].mag[mwsf_pkg::SPEED_W-1:0];

		mwsf_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (lane_cmd[i]),
			.status (lane_st[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			hold_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				hold_valid_q <= 1'b1;
			end else if (take) begin
				hold_valid_q <= 1'b0;
			end
			case (state_q)
				F_IDLE: begin
					if (hold_valid_q) begin
						state_q <= F_SUM;
					end
				end
				F_SUM:   state_q <= F_GAIN;
				F_GAIN:  state_q <= F_GAIN_WAIT;
				F_GAIN_WAIT: begin
					if (!any_busy) begin
						state_q <= F_MAX;
					end
				end
				F_MAX:   state_q <= F_CHECK;
				F_CHECK: state_q <= over_limit ? F_LIMIT_WAIT : F_PUSH;
				F_LIMIT_WAIT: begin
					if (!any_busy) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!queue_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q <= vel_forward_mm_s;
			vy_q <= vel_lateral_mm_s;
			wz_q <= yaw_rate_mrad_s;
		end
		if (take) begin
			rot_q       <= rot;
			diff_base_q <= diff_base;
			add_base_q  <= add_base;
		end
		if (state_q == F_SUM) begin
			s_q[0] <= diff_base_q - rot_q;
			s_q[1] <= add_base_q + rot_q;
			s_q[2] <= add_base_q - rot_q;
			s_q[3] <= diff_base_q + rot_q;
		end
		if (state_q == F_MAX) begin
			peak_q <= max_all;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !queue_full)
		else $error("speed set pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_PUSH) |->
			(lane_st[0].mag <= mwsf_pkg::MAG_W'(speed_limit)) &&
			(lane_st[1].mag <= mwsf_pkg::MAG_W'(speed_limit)) &&
			(lane_st[2].mag <= mwsf_pkg::MAG_W'(speed_limit)) &&
			(lane_st[3].mag <= mwsf_pkg::MAG_W'(speed_limit)))
		else $error("wheel speed above the limit after scaling");
`endif

endmodule

### rtl/mwsf_queue.sv
module mwsf_queue #(
	parameter int DEPTH = mwsf_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mwsf_pkg::speed_set_t  push_data,
	output logic                  full,
	input  logic                  pop,
	output mwsf_pkg::speed_set_t  pop_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mwsf_pkg::speed_set_t  entries_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/mwsf_back.sv
module mwsf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	output logic                          pop,
	input  mwsf_pkg::speed_set_t          pop_data,
	input  logic                          empty,
	output logic                          frame_valid,
	input  logic                          frame_stall,
	output logic [mwsf_pkg::BYTE_W-1:0]   frame_byte,
	output logic                          frame_last
);

	typedef enum logic [2:0] {B_EMPTY, B_START, B_TAG, B_LO, B_HI, B_END} back_state_t;

	back_state_t                     state_q;
	logic [mwsf_pkg::WHEEL_W-1:0]    wheel_q;
	mwsf_pkg::speed_set_t            speeds_q;
	logic                            valid_q;
	logic [mwsf_pkg::BYTE_W-1:0]     byte_q;
	logic                            last_q;
	logic                            out_free;

	assign out_free    = !valid_q || !frame_stall;
	// next set is fetched while the closing byte goes out
	assign pop         = !empty && ((state_q == B_EMPTY) || ((state_q == B_END) && out_free));
	assign frame_valid = valid_q;
	assign frame_byte  = byte_q;
	assign frame_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_EMPTY;
			wheel_q  <= '0;
			speeds_q <= '0;
			valid_q  <= 1'b0;
			byte_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			if (out_free) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				B_EMPTY: begin
					if (!empty) begin
						speeds_q <= pop_data;
						state_q  <= B_START;
					end
				end
				B_START: begin
					if (out_free) begin
						valid_q <= 1'b1;
						byte_q  <= mwsf_pkg::FRAME_START;
						last_q  <= 1'b0;
						wheel_q <= '0;
						state_q <= B_TAG;
					end
				end
				B_TAG: begin
					if (out_free) begin
						valid_q <= 1'b1;
						byte_q  <= mwsf_pkg::TAG_FIRST + mwsf_pkg::BYTE_W'(wheel_q);
						last_q  <= 1'b0;
						state_q <= B_LO;
					end
				end
				B_LO: begin
					if (out_free) begin
						valid_q <= 1'b1;
						byte_q  <= speeds_q[wheel_q][mwsf_pkg::BYTE_W-1:0];
						last_q  <= 1'b0;
						state_q <= B_HI;
					end
				end
				B_HI: begin
					if (out_free) begin
						valid_q <= 1'b1;
						byte_q  <= speeds_q[wheel_q][mwsf_pkg::SPEED_W-1:mwsf_pkg::BYTE_W];
						last_q  <= 1'b0;
						if (wheel_q == mwsf_pkg::WHEEL_W'(mwsf_pkg::WHEELS - 1)) begin
							state_q <= B_END;
						end else begin
							wheel_q <= wheel_q + 1'b1;
							state_q <= B_TAG;
						end
					end
				end
				B_END: begin
					if (out_free) begin
						valid_q <= 1'b1;
						byte_q  <= mwsf_pkg::FRAME_END;
						last_q  <= 1'b1;
						if (!empty) begin
							speeds_q <= pop_data;
							state_q  <= B_START;
						end else begin
							state_q <= B_EMPTY;
						end
					end
				end
				default: state_q <= B_EMPTY;
			endcase
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && frame_last) |-> (frame_byte == mwsf_pkg::FRAME_END))
		else $error("frame end flag on a byte other than the closing byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && !frame_stall && frame_last) |=>
			(!frame_valid || (frame_byte == mwsf_pkg::FRAME_START)))
		else $error("byte after a closing byte is not a start byte");
`endif

endmodule

### rtl/mecanum_wheel_speed_framer.sv
// channel  dir  handshake                  payload
// cmd      in   cmd_valid / cmd_stall      vel_forward_mm_s, vel_lateral_mm_s, yaw_rate_mrad_s
// frame    out  frame_valid / frame_stall  frame_byte, frame_last
// cfg      in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// the front scales the speeds by the limit only when the largest one exceeds it; each
// wheel unit does the gain and the divide by 1000, then the limit divide when needed
// frames leave at one byte a cycle when not stalled, back to back while sets are queued
// an input holding register and the speed queue let the next command start mid-frame
// reset clears control state and loads the register defaults; cfg_ready stays high
module mecanum_wheel_speed_framer #(
	parameter int QUEUE_DEPTH = mwsf_pkg::QUEUE_DEPTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cmd_valid,
	output logic                                    cmd_stall,
	input  logic signed [mwsf_pkg::VEL_W-1:0]       vel_forward_mm_s,
	input  logic signed [mwsf_pkg::VEL_W-1:0]       vel_lateral_mm_s,
	input  logic signed [mwsf_pkg::VEL_W-1:0]       yaw_rate_mrad_s,
	output logic                                    frame_valid,
	input  logic                                    frame_stall,
	output logic [mwsf_pkg::BYTE_W-1:0]             frame_byte,
	output logic                                    frame_last,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [mwsf_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [mwsf_pkg::CFG_DATA_W-1:0]         cfg_data
);

	logic [mwsf_pkg::GAIN_W-1:0]   gain_q;
	logic [mwsf_pkg::AXLE_W-1:0]   axle_q;
	logic [mwsf_pkg::LIMIT_W-1:0]  limit_q;

	logic                          push;
	mwsf_pkg::speed_set_t          push_data;
	logic                          queue_full;
	logic                          pop;
	mwsf_pkg::speed_set_t          pop_data;
	logic                          queue_empty;

	assign cfg_ready = 1'b1;

	// writes to an index beyond the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= mwsf_pkg::GAIN_RESET;
			axle_q  <= mwsf_pkg::AXLE_RESET;
			limit_q <= mwsf_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mwsf_pkg::REG_SPEED_GAIN:  gain_q  <= cfg_data[mwsf_pkg::GAIN_W-1:0];
				mwsf_pkg::REG_AXLE_SUM:    axle_q  <= cfg_data[mwsf_pkg::AXLE_W-1:0];
				mwsf_pkg::REG_SPEED_LIMIT: limit_q <= cfg_data[mwsf_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	mwsf_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_stall        (cmd_stall),
		.vel_forward_mm_s (vel_forward_mm_s),
		.vel_lateral_mm_s (vel_lateral_mm_s),
		.yaw_rate_mrad_s  (yaw_rate_mrad_s),
		.speed_gain_q16   (gain_q),
		.axle_sum_mm      (axle_q),
		.speed_limit      (limit_q),
		.push             (push),
		.push_data        (push_data),
		.queue_full       (queue_full)
	);

	mwsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (queue_empty)
	);

	mwsf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop         (pop),
		.pop_data    (pop_data),
		.empty       (queue_empty),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_byte  (frame_byte),
		.frame_last  (frame_last)
	);

endmodule
